/* rtl/core/stereo_feedback_delay_assert.svh */
// assertion macros for the stereo feedback delay checker
// no dependencies; included by the checker file only
`ifndef STEREO_FEEDBACK_DELAY_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_ASSERT_SVH

// same-cycle implication, disabled while rst_n is low
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stereo_feedback_delay check failed");

// next-cycle implication, disabled while rst_n is low
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stereo_feedback_delay check failed");

`endif

/* rtl/core/sfd_pkg.sv */
// shared types, constants and helper functions for the stereo feedback delay
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int DEPTH       = 65536;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int SAMPLE_W    = 24;
    localparam int GAIN_W      = 16;
    localparam int DELAY_CFG_W = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = SAMPLE_W + GAIN_W;
    localparam int CALC_W      = ((ADDR_W > DELAY_CFG_W) ? ADDR_W : DELAY_CFG_W) + 5;

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]          t_gain;
    typedef logic signed [PROD_W-1:0]   t_prod;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_DELAY    = 2'd0,
        CFG_FEEDBACK_GAIN = 2'd1,
        CFG_MIX_GAIN      = 2'd2,
        CFG_TWO_CHANNELS  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic  adv;
        logic  issue;
        logic  proc;
        t_addr rd_addr;
        t_addr wr_addr;
        logic  clr_we;
        t_addr clr_addr;
        t_gain fb_gain;
        t_gain mix_gain;
    } t_lane_ctl;

    // clamp a sum of two samples back into the sample range
    function automatic t_sample sat_sample(input logic [SAMPLE_W:0] x);
        t_sample y;
        if (x[SAMPLE_W] != x[SAMPLE_W-1]) begin
            y = x[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            y = x[SAMPLE_W-1:0];
        end
        return y;
    endfunction

    // round half up, then floor of the division by 2^GAIN_W
    function automatic t_sample round_gain(input t_prod p);
        t_prod t;
        t = p + PROD_W'(2 ** (GAIN_W - 1));
        return t[PROD_W-1:GAIN_W];
    endfunction

    function automatic t_addr left_delay(input logic [DELAY_CFG_W-1:0] bd);
        logic [CALC_W-1:0] b;
        b = CALC_W'(bd);
        if (b == '0) begin
            b = CALC_W'(1);
        end
        if (b > CALC_W'(DEPTH - 1)) begin
            b = CALC_W'(DEPTH - 1);
        end
        return b[ADDR_W-1:0];
    endfunction

    // (dl * 9 + 4) / 8, limited to the last entry
    function automatic t_addr right_delay(input t_addr dl);
        logic [CALC_W-1:0] t;
        t = (CALC_W'(dl) << 3) + CALC_W'(dl) + CALC_W'(4);
        t = t >> 3;
        if (t > CALC_W'(DEPTH - 1)) begin
            t = CALC_W'(DEPTH - 1);
        end
        return t[ADDR_W-1:0];
    endfunction

    function automatic t_addr ring_sub(input t_addr a, input t_addr d);
        logic [ADDR_W:0] t;
        if (a >= d) begin
            t = {1'b0, a} - {1'b0, d};
        end else begin
            t = {1'b0, a} + (ADDR_W+1)'(DEPTH) - {1'b0, d};
        end
        return t[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/core/sfd_store.sv */
// one channel's circular delay memory: one write port, one registered read port
// depends on sfd_pkg
`timescale 1ns / 1ps

module sfd_store import sfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_we,
    input  t_addr   i_waddr,
    input  t_sample i_wdata,
    input  logic    i_re,
    input  t_addr   i_raddr,
    output t_sample o_rdata
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    t_sample             r_rdata;

    // read returns the old contents when the same entry is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sfd_lane.sv */
// one channel datapath: memory read, forwarding, gain multiply, add and write back
// depends on sfd_pkg and sfd_store
`timescale 1ns / 1ps

module sfd_lane import sfd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  t_sample   i_dry,
    output t_sample   o_result
);

    logic    r_s1_proc;
    t_sample r_s1_dry;
    t_addr   r_s1_raddr;
    t_addr   r_s1_waddr;
    logic    r_s2_proc;
    t_sample r_s2_dry;
    t_addr   r_s2_waddr;
    t_prod   r_s2_pfb;
    t_prod   r_s2_pmix;
    logic    r_fwd_valid;
    t_addr   r_fwd_addr;
    t_sample r_fwd_data;

    t_sample rd_data;
    t_sample delayed;
    t_sample fb_scaled;
    t_sample mix_scaled;
    t_sample store_val;
    logic signed [PROD_W:0] pfb_full;
    logic signed [PROD_W:0] pmix_full;
    logic    mem_we;
    t_addr   mem_waddr;
    t_sample mem_wdata;

    sfd_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_ctl.issue),
        .i_raddr (i_ctl.rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        fb_scaled  = round_gain(r_s2_pfb);
        mix_scaled = round_gain(r_s2_pmix);
        store_val  = sat_sample({r_s2_dry[SAMPLE_W-1], r_s2_dry}
                              + {fb_scaled[SAMPLE_W-1], fb_scaled});
        o_result   = r_s2_proc ? sat_sample({r_s2_dry[SAMPLE_W-1], r_s2_dry}
                                          + {mix_scaled[SAMPLE_W-1], mix_scaled})
                               : r_s2_dry;
    end

    // newest pending write wins, then the one that raced the memory read
    always_comb begin
        if (r_s2_proc && (r_s1_raddr == r_s2_waddr)) begin
            delayed = store_val;
        end else if (r_fwd_valid && (r_s1_raddr == r_fwd_addr)) begin
            delayed = r_fwd_data;
        end else begin
            delayed = rd_data;
        end
        pfb_full  = delayed * $signed({1'b0, i_ctl.fb_gain});
        pmix_full = delayed * $signed({1'b0, i_ctl.mix_gain});
    end

    always_comb begin
        mem_we    = i_ctl.clr_we || (i_ctl.adv && r_s2_proc);
        mem_waddr = i_ctl.clr_we ? i_ctl.clr_addr : r_s2_waddr;
        mem_wdata = i_ctl.clr_we ? '0 : store_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_proc   <= 1'b0;
            r_s2_proc   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else if (i_ctl.adv) begin
            r_s1_proc   <= i_ctl.issue && i_ctl.proc;
            r_s2_proc   <= r_s1_proc;
            r_fwd_valid <= r_s2_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_s1_dry   <= i_dry;
            r_s1_raddr <= i_ctl.rd_addr;
            r_s1_waddr <= i_ctl.wr_addr;
            r_s2_dry   <= r_s1_dry;
            r_s2_waddr <= r_s1_waddr;
            r_s2_pfb   <= pfb_full[PROD_W-1:0];
            r_s2_pmix  <= pmix_full[PROD_W-1:0];
            r_fwd_addr <= r_s2_waddr;
            r_fwd_data <= store_val;
        end
    end

endmodule

/* rtl/core/stereo_feedback_delay.sv */
// top level of the stereo feedback delay: config registers, pointer, clear sequencer
// depends on sfd_pkg and sfd_lane
`timescale 1ns / 1ps

// Stereo echo with feedback, one frame per beat. A frame is accepted every
// cycle once the block is running; its result passes the memory read at the
// accepting edge, then gain multiply, then add/saturate/write back into the
// output register. The rate is set by the feedback loop through the add stage
// and the multiply stage, closed by forwarding from the pending write to the
// read data. When the output beat is stalled the whole pipeline holds and the
// input is stalled. After reset the block clears all DEPTH (65536) entries of
// both delay memories, one entry per cycle, with the input stalled;
// configuration writes are taken during that time. Right delay is
// round(left * 9/8), capped at the last entry. Configuration must only change
// while no frame is in flight.

module stereo_feedback_delay import sfd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_sample              i_left_in,
    input  t_sample              i_right_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_sample              o_left_out,
    output t_sample              o_right_out
);

    t_state  r_state;
    t_state  n_state;
    t_addr   r_clr_addr;
    t_addr   r_dl;
    t_addr   r_dr;
    t_gain   r_fb_gain;
    t_gain   r_mix_gain;
    logic    r_two_ch;
    t_addr   r_wp;
    logic    r_s1_valid;
    logic    r_s2_valid;
    logic    r_out_valid;
    t_sample r_left_out;
    t_sample r_right_out;

    logic      clr_we;
    logic      running;
    logic      adv;
    logic      accept;
    logic      active;
    t_addr     n_wp;
    t_lane_ctl left_ctl;
    t_lane_ctl right_ctl;
    t_sample   left_res;
    t_sample   right_res;

    always_comb begin
        case (r_state)
            ST_CLEAR: n_state = (r_clr_addr == ADDR_W'(DEPTH - 1)) ? ST_RUN : ST_CLEAR;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: begin
                clr_we  = 1'b1;
                running = 1'b0;
            end
            ST_RUN: begin
                clr_we  = 1'b0;
                running = 1'b1;
            end
            default: begin
                clr_we  = 1'b0;
                running = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // delays are clamped and derived when written, so the item path only subtracts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl       <= ADDR_W'(1);
            r_dr       <= ADDR_W'(1);
            r_fb_gain  <= '0;
            r_mix_gain <= '0;
            r_two_ch   <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_DELAY: begin
                    r_dl <= left_delay(i_cfg_data[DELAY_CFG_W-1:0]);
                    r_dr <= right_delay(left_delay(i_cfg_data[DELAY_CFG_W-1:0]));
                end
                CFG_FEEDBACK_GAIN: r_fb_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_MIX_GAIN:      r_mix_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_TWO_CHANNELS:  r_two_ch   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        adv        = !(r_out_valid && i_out_stall);
        o_in_stall = !running || !adv;
        accept     = i_in_valid && !o_in_stall;
        active     = (r_fb_gain != '0) || (r_mix_gain != '0);
        n_wp       = (r_wp == ADDR_W'(DEPTH - 1)) ? '0 : r_wp + ADDR_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (accept && active) begin
            r_wp <= n_wp;
        end
    end

    always_comb begin
        left_ctl.adv       = adv;
        left_ctl.issue     = accept;
        left_ctl.proc      = active;
        left_ctl.rd_addr   = ring_sub(r_wp, r_dl);
        left_ctl.wr_addr   = r_wp;
        left_ctl.clr_we    = clr_we;
        left_ctl.clr_addr  = r_clr_addr;
        left_ctl.fb_gain   = r_fb_gain;
        left_ctl.mix_gain  = r_mix_gain;

        right_ctl          = left_ctl;
        right_ctl.proc     = active && r_two_ch;
        right_ctl.rd_addr  = ring_sub(r_wp, r_dr);
    end

    sfd_lane u_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (left_ctl),
        .i_dry    (i_left_in),
        .o_result (left_res)
    );

    sfd_lane u_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (right_ctl),
        .i_dry    (i_right_in),
        .o_result (right_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid) begin
            r_left_out  <= left_res;
            r_right_out <= right_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

endmodule

/* rtl/core/sfd_checker.sv */
// port-level checks for the stereo feedback delay, bound to the top level
// depends on sfd_pkg and stereo_feedback_delay_assert.svh
`timescale 1ns / 1ps
`include "stereo_feedback_delay_assert.svh"

module sfd_checker import sfd_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_sample              i_left_in,
    input t_sample              i_right_in,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_sample              o_left_out,
    input t_sample              o_right_out
);

    // a stalled result beat stays up and keeps its payload
    `SFD_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `SFD_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_left_out) && $stable(o_right_out))

    // a held result freezes the pipeline, so no new beat may enter
    `SFD_ASSERT_NOW(a_in_stalls_on_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)

    // reset starts the memory clear with the input stalled and the output empty
    `SFD_ASSERT_NEXT(a_clear_after_reset, i_clk, 1'b1, !i_rst_n, o_in_stall)
    `SFD_ASSERT_NEXT(a_empty_after_reset, i_clk, 1'b1, !i_rst_n, !o_out_valid)

endmodule

bind stereo_feedback_delay sfd_checker u_sfd_checker (.*);
